>>> hdl/awse_pkg.sv
// Shared types, constants and codes for the age-weighted size eviction unit.
package awse_pkg;

	// Table geometry
	localparam int ENTRIES = 32;
	localparam int IDX_W   = $clog2(ENTRIES);

	// Field widths
	localparam int KIND_W  = 2;
	localparam int SLOT_W  = 5;
	localparam int SIZE_W  = 32;
	localparam int AGE_W   = 24;
	localparam int PROD_W  = SIZE_W + AGE_W;
	localparam int WGT_W   = SIZE_W + 1;
	localparam int QCNT_W  = $clog2(SIZE_W);

	// Stream widths (tdata padded to whole bytes)
	localparam int S_FIELD_W = SLOT_W + 1 + SIZE_W + AGE_W + AGE_W;
	localparam int S_DATA_W  = ((S_FIELD_W + 7) / 8) * 8;
	localparam int M_FIELD_W = SLOT_W + WGT_W;
	localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EVICT  = 2'd2;

	// Largest load age
	localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

	// One stored table entry (valid bit kept apart in flops)
	typedef struct packed {
		logic              evictable;
		logic [AGE_W-1:0]  age;
		logic [SIZE_W-1:0] size;
	} entry_t;

endpackage

>>> hdl/awse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module awse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/awse_div.sv
// Restoring divider, one quotient bit per cycle, for a quotient known to fit SIZE_W bits.
module awse_div
	import awse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [AGE_W-1:0]  divisor,
	output logic              done,
	output logic [SIZE_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [AGE_W-1:0]  rem_q;
	logic [AGE_W-1:0]  div_q;
	logic [SIZE_W-1:0] quo_q;

	logic [AGE_W:0]    trial;
	logic [AGE_W:0]    diff;
	logic              ge;

	// Shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[SIZE_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == QCNT_W'(SIZE_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == QCNT_W'(SIZE_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath; high dividend bits start as remainder (always below divisor)
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PROD_W-1:SIZE_W];
			quo_q <= dividend[SIZE_W-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[AGE_W-1:0] : trial[AGE_W-1:0];
			quo_q <= {quo_q[SIZE_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hdl/age_weighted_size_eviction_unit.sv
// Top level of the age-weighted size eviction unit: table, sequencer and result register.
//
// A write or remove beat updates one table slot and returns an all-zero result. An evict
// beat walks the table through the single RAM read port: a first pass finds the age range
// of the eligible entries and, if there is any, a second pass reads each slot again and,
// for an eligible entry with a nonzero age span, multiplies once and runs the shared
// one-bit-per-cycle divider. The input is not ready while a request is in work, and a
// finished result waits in the output register until it is taken.
module age_weighted_size_eviction_unit
	import awse_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// slot[4:0], evictable[5], size_bytes[37:6], load_age[61:38], current_count[85:62]
	input  logic [S_DATA_W-1:0] s_tdata,
	// kind[1:0]
	input  logic [KIND_W-1:0]   s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// victim_slot[4:0], weighted_size[37:5]
	output logic [M_DATA_W-1:0] m_tdata,
	// evicted[0]
	output logic [0:0]          m_tuser
);

	// Sequencer states
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN_RD = 3'd1;
	localparam logic [2:0] ST_SCAN_EV = 3'd2;
	localparam logic [2:0] ST_W_RD    = 3'd3;
	localparam logic [2:0] ST_W_EV    = 3'd4;
	localparam logic [2:0] ST_W_MUL   = 3'd5;
	localparam logic [2:0] ST_W_DIV   = 3'd6;
	localparam logic [2:0] ST_OUT     = 3'd7;

	// Input fields
	logic [SLOT_W-1:0] in_slot;
	logic              in_evictable;
	logic [SIZE_W-1:0] in_size;
	logic [AGE_W-1:0]  in_age;
	logic [AGE_W-1:0]  in_count;

	assign in_slot      = s_tdata[SLOT_W-1:0];
	assign in_evictable = s_tdata[SLOT_W];
	assign in_size      = s_tdata[SLOT_W+SIZE_W:SLOT_W+1];
	assign in_age       = s_tdata[SLOT_W+SIZE_W+AGE_W:SLOT_W+SIZE_W+1];
	assign in_count     = s_tdata[S_FIELD_W-1:SLOT_W+SIZE_W+AGE_W+1];

	logic [2:0]        state_q;
	logic [ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]  idx_q;
	logic [AGE_W-1:0]  count_q;
	logic [AGE_W-1:0]  min_q;
	logic [AGE_W-1:0]  max_q;
	logic              any_q;
	logic [AGE_W-1:0]  span_q;
	logic [PROD_W-1:0] prod_q;
	logic [SIZE_W-1:0] sz_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [WGT_W-1:0]  best_w_q;
	logic              res_evicted_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [WGT_W-1:0]  res_w_q;
	logic              m_tvalid_q;
	logic              out_evicted_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [WGT_W-1:0]  out_w_q;

	logic              accept;
	logic              slot_ok;
	logic              ram_we;
	entry_t            ram_wdata;
	entry_t            rd;
	logic              eligible;
	logic              last;
	logic              div_start;
	logic              div_done;
	logic [SIZE_W-1:0] div_quo;
	logic [AGE_W-1:0]  age_diff;
	logic [PROD_W-1:0] prod_d;
	logic              cand_valid;
	logic [WGT_W-1:0]  cand_w;
	logic              take;
	logic              advance;
	logic [IDX_W-1:0]  fin_idx;
	logic [WGT_W-1:0]  fin_w;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign slot_ok  = 32'(in_slot) < ENTRIES;
	assign last     = idx_q == IDX_W'(ENTRIES - 1);

	// Table write port
	assign ram_we    = accept && (s_tuser == KIND_WRITE) && slot_ok;
	assign ram_wdata = '{evictable: in_evictable, age: in_age, size: in_size};

	awse_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IDX_W'(in_slot)),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (rd)
	);

	// Eligibility of the slot just read
	assign eligible = valid_q[idx_q] && rd.evictable && (rd.size != '0) &&
		(({1'b0, rd.age} + 1'b1) < {1'b0, count_q});

	// Weight numerator: size * (max_age - age)
	assign age_diff = max_q - rd.age;
	assign prod_d   = PROD_W'(rd.size) * PROD_W'(age_diff);

	awse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (span_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign div_start = (state_q == ST_W_MUL);

	// Candidate weight from the second pass
	always_comb begin
		cand_valid = 1'b0;
		cand_w     = '0;
		advance    = 1'b0;
		if (state_q == ST_W_EV) begin
			cand_valid = eligible && (span_q == '0);
			cand_w     = {1'b0, rd.size};
			advance    = !eligible || (span_q == '0);
		end else if (state_q == ST_W_DIV) begin
			cand_valid = div_done;
			cand_w     = {1'b0, sz_q} + {1'b0, div_quo};
			advance    = div_done;
		end
	end

	// Strictly larger wins, so the lowest slot keeps a tie
	assign take    = cand_valid && (cand_w > best_w_q);
	assign fin_idx = take ? idx_q : best_idx_q;
	assign fin_w   = take ? cand_w : best_w_q;

	// Sequencer and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (s_tuser == KIND_EVICT) begin
							state_q <= ST_SCAN_RD;
						end else begin
							state_q <= ST_OUT;
							if (s_tuser == KIND_WRITE && slot_ok) begin
								valid_q[IDX_W'(in_slot)] <= 1'b1;
							end else if (s_tuser == KIND_REMOVE && slot_ok) begin
								valid_q[IDX_W'(in_slot)] <= 1'b0;
							end
						end
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_EV;
				end
				ST_SCAN_EV: begin
					if (last) begin
						idx_q   <= '0;
						state_q <= (any_q || eligible) ? ST_W_RD : ST_OUT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_W_RD: begin
					state_q <= ST_W_EV;
				end
				ST_W_EV, ST_W_DIV: begin
					if (state_q == ST_W_EV && eligible && span_q != '0) begin
						state_q <= ST_W_MUL;
					end else if (advance) begin
						if (last) begin
							valid_q[fin_idx] <= 1'b0;
							state_q          <= ST_OUT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_W_RD;
						end
					end
				end
				ST_W_MUL: begin
					state_q <= ST_W_DIV;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Evict datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			count_q       <= in_count;
			min_q         <= AGE_MAX;
			max_q         <= '0;
			any_q         <= 1'b0;
			best_w_q      <= '0;
			best_idx_q    <= '0;
			res_evicted_q <= 1'b0;
			res_slot_q    <= '0;
			res_w_q       <= '0;
		end
		// First pass: age range
		if (state_q == ST_SCAN_EV && eligible) begin
			any_q <= 1'b1;
			if (rd.age < min_q) begin
				min_q <= rd.age;
			end
			if (rd.age > max_q) begin
				max_q <= rd.age;
			end
		end
		// Span folds in the last slot, whose age is not yet in the range registers
		if (state_q == ST_SCAN_EV && last) begin
			if (eligible && rd.age > max_q && !(rd.age < min_q)) begin
				span_q <= rd.age - min_q;
			end else if (eligible && rd.age < min_q && !(rd.age > max_q)) begin
				span_q <= max_q - rd.age;
			end else if (eligible && rd.age < min_q && rd.age > max_q) begin
				span_q <= '0;
			end else begin
				span_q <= max_q - min_q;
			end
		end
		// Second pass: multiply ahead of the divider
		if (state_q == ST_W_EV) begin
			prod_q <= prod_d;
			sz_q   <= rd.size;
		end
		if (take) begin
			best_w_q   <= cand_w;
			best_idx_q <= idx_q;
		end
		if ((state_q == ST_W_EV || state_q == ST_W_DIV) && advance && last) begin
			res_evicted_q <= 1'b1;
			res_slot_q    <= SLOT_W'(fin_idx);
			res_w_q       <= fin_w;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
			out_evicted_q <= res_evicted_q;
			out_slot_q    <= res_slot_q;
			out_w_q       <= res_w_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_DATA_W - M_FIELD_W){1'b0}}, out_w_q, out_slot_q};
	assign m_tuser  = out_evicted_q;

endmodule

>>> hdl/awse_checker.sv
// Port-level checks for the age-weighted size eviction unit, bound to the top level.
module awse_checker
	import awse_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [0:0]          m_tuser
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// One request at a time: busy right after a beat is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a request is in work");

	// No eviction means an all-zero result
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("nonzero payload without eviction");

	// A victim always has a nonzero weight
	a_weight: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[M_FIELD_W-1:SLOT_W] != '0)
		else $error("evicted entry with zero weight");

endmodule

bind age_weighted_size_eviction_unit awse_checker u_awse_checker (.*);
